### rtl/core/ffri_pkg.sv
// Shared constants, types and codes of the frame flip / rotate / invert block.
package ffri_pkg;

  // Largest source frame and the byte store that holds it.
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int PIX_BYTES   = 3;
  localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * PIX_BYTES;

  // Field widths fixed by the register map and the item format.
  localparam int MODE_W     = 3;
  localparam int CFG_DIM_W  = 9;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CFG_DIM_W;

  // Internal widths derived from the frame limits.
  localparam int DIM_BITS = $clog2(MAX_DIM + 1);
  localparam int DIM_W    = (DIM_BITS > CFG_DIM_W) ? DIM_BITS : CFG_DIM_W;
  localparam int COORD_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PIX_CNT  = MAX_WIDTH * MAX_HEIGHT;
  localparam int PIX_W    = (PIX_CNT > 1) ? $clog2(PIX_CNT) : 1;
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
  localparam int CHAN_W   = 2;

  // Register reset values.
  localparam int RST_WIDTH  = 256;
  localparam int RST_HEIGHT = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_COLOR  = 2'd3
  } reg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_INVERT  = 3'd0,
    MODE_MIRROR  = 3'd1,
    MODE_FLIP    = 3'd2,
    MODE_ROT_CW  = 3'd3,
    MODE_ROT_CCW = 3'd4
  } mode_e;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic capture;  // latch the input byte of a transfer
    logic area;     // register width times height
    logic store;    // write one source byte, advance the load count
    logic pos;      // map the readout position to source coordinates
    logic mul;      // source row times width
    logic addr;     // finish the byte address
    logic read;     // read the frame store
    logic result;   // load the output register
  } ffri_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic readout;  // frame complete, fetches are served
    logic out_free; // output register may be loaded this cycle
  } ffri_sts_t;

endpackage

### rtl/core/ffri_in_if.sv
// Input channel: load and fetch items with a valid/ready handshake.
interface ffri_in_if;
  import ffri_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] data_in;

  modport source (output valid, output kind, output data_in, input ready);
  modport sink   (input valid, input kind, input data_in, output ready);
endinterface

### rtl/core/ffri_out_if.sv
// Output channel: transformed frame bytes with a valid/ready handshake.
interface ffri_out_if;
  import ffri_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;
  logic              last;

  modport source (output valid, output data_out, output last, input ready);
  modport sink   (input valid, input data_out, input last, output ready);
endinterface

### rtl/core/ffri_ctrl.sv
// Sequencer of the frame block: steps each load or fetch through the datapath.
module ffri_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  output logic               in_ready_o,
  input  ffri_pkg::ffri_sts_t sts_i,
  output ffri_pkg::ffri_cmd_t cmd_o
);
  import ffri_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_AREA   = 8'b0000_0010,
    S_STORE  = 8'b0000_0100,
    S_POS    = 8'b0000_1000,
    S_MUL    = 8'b0001_0000,
    S_ADDR   = 8'b0010_0000,
    S_READ   = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        // Loads during readout and fetches during loading are dropped here.
        if (in_valid_i) begin
          if (!sts_i.readout && in_kind_i == KIND_LOAD) begin
            state_d = S_AREA;
          end else if (sts_i.readout && in_kind_i == KIND_FETCH) begin
            state_d = S_POS;
          end
        end
      end
      S_AREA:   state_d = S_STORE;
      S_STORE:  state_d = S_IDLE;
      S_POS:    state_d = S_MUL;
      S_MUL:    state_d = S_ADDR;
      S_ADDR:   state_d = S_READ;
      S_READ:   state_d = S_RESULT;
      S_RESULT: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.area     = (state_q == S_AREA);
  assign cmd_o.store    = (state_q == S_STORE);
  assign cmd_o.pos      = (state_q == S_POS);
  assign cmd_o.mul      = (state_q == S_MUL);
  assign cmd_o.addr     = (state_q == S_ADDR);
  assign cmd_o.read     = (state_q == S_READ);
  assign cmd_o.result   = (state_q == S_RESULT) && sts_i.out_free;

endmodule

### rtl/core/ffri_dp.sv
// Datapath of the frame block: registers, frame store, address arithmetic, output register.
module ffri_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ffri_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ffri_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [ffri_pkg::BYTE_W-1:0]      in_data_i,
  input  ffri_pkg::ffri_cmd_t              cmd_i,
  output ffri_pkg::ffri_sts_t              sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [ffri_pkg::BYTE_W-1:0]      out_data_o,
  output logic                             out_last_o
);
  import ffri_pkg::*;

  // Configuration registers.
  logic [MODE_W-1:0]    cfg_mode_q;
  logic [CFG_DIM_W-1:0] cfg_width_q;
  logic [CFG_DIM_W-1:0] cfg_height_q;
  logic                 cfg_color_q;

  // Control state.
  logic               readout_q;
  logic [CNT_W-1:0]   load_cnt_q;
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  logic [CHAN_W-1:0]  chan_q;
  logic               out_valid_q;

  // Payload registers.
  logic [BYTE_W-1:0]  data_q;
  logic [CNT_W-1:0]   area_q;
  logic [COORD_W-1:0] sr_q;
  logic [COORD_W-1:0] sc_q;
  logic [CHAN_W-1:0]  k_q;
  logic               oob_q;
  logic               last_q;
  logic [PIX_W-1:0]   prod_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [BYTE_W-1:0]  rd_q;
  logic [BYTE_W-1:0]  out_data_q;
  logic               out_last_q;

  logic [BYTE_W-1:0] frame_mem [STORE_DEPTH];

  function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_DIM_W-1:0] v,
                                                  logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] ext;
    ext = DIM_W'(v);
    if (ext == '0) begin
      return DIM_W'(1);
    end else if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

  logic [DIM_W-1:0]   w, h, ow, oh, r_ext, c_ext;
  logic [CHAN_W-1:0]  last_chan;
  logic               rotated, oob, is_last;
  logic [DIM_W-1:0]   sr_full, sc_full;
  logic [COORD_W-1:0] row_nxt, col_nxt;
  logic [CHAN_W-1:0]  chan_nxt;
  logic [CNT_W-1:0]   total;
  logic               store_en, frame_done;
  logic [PIX_W-1:0]   pix;
  logic [ADDR_W-1:0]  pix_addr;

  always_comb begin
    w         = clamp_dim(cfg_width_q, DIM_W'(MAX_WIDTH));
    h         = clamp_dim(cfg_height_q, DIM_W'(MAX_HEIGHT));
    last_chan = cfg_color_q ? CHAN_W'(PIX_BYTES - 1) : '0;
    rotated   = (cfg_mode_q == MODE_ROT_CW) || (cfg_mode_q == MODE_ROT_CCW);
    ow        = rotated ? h : w;
    oh        = rotated ? w : h;
    r_ext     = DIM_W'(row_q);
    c_ext     = DIM_W'(col_q);

    // A position beyond the current frame ends the readout with a zero byte.
    oob     = (r_ext >= oh) || (c_ext >= ow) || (chan_q > last_chan);
    is_last = (r_ext == oh - 1'b1) && (c_ext == ow - 1'b1) && (chan_q == last_chan);

    unique case (cfg_mode_q)
      MODE_MIRROR: begin
        sr_full = r_ext;
        sc_full = w - 1'b1 - c_ext;
      end
      MODE_FLIP: begin
        sr_full = h - 1'b1 - r_ext;
        sc_full = c_ext;
      end
      MODE_ROT_CW: begin
        sr_full = h - 1'b1 - c_ext;
        sc_full = r_ext;
      end
      MODE_ROT_CCW: begin
        sr_full = c_ext;
        sc_full = w - 1'b1 - r_ext;
      end
      default: begin
        sr_full = r_ext;
        sc_full = c_ext;
      end
    endcase

    row_nxt  = row_q;
    col_nxt  = col_q;
    chan_nxt = chan_q + 1'b1;
    if (chan_q == last_chan) begin
      chan_nxt = '0;
      if (c_ext == ow - 1'b1) begin
        col_nxt = '0;
        row_nxt = row_q + 1'b1;
      end else begin
        col_nxt = col_q + 1'b1;
      end
    end

    total      = cfg_color_q ? ((area_q << 1) + area_q) : area_q;
    store_en   = (load_cnt_q < total);
    frame_done = (load_cnt_q >= total - 1'b1);

    pix      = prod_q + PIX_W'(sc_q);
    pix_addr = cfg_color_q ? ((ADDR_W'(pix) << 1) + ADDR_W'(pix)) : ADDR_W'(pix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q   <= MODE_INVERT;
      cfg_width_q  <= CFG_DIM_W'(RST_WIDTH);
      cfg_height_q <= CFG_DIM_W'(RST_HEIGHT);
      cfg_color_q  <= 1'b0;
      readout_q    <= 1'b0;
      load_cnt_q   <= '0;
      row_q        <= '0;
      col_q        <= '0;
      chan_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_MODE:   cfg_mode_q   <= cfg_data_i[MODE_W-1:0];
          REG_WIDTH:  cfg_width_q  <= cfg_data_i[CFG_DIM_W-1:0];
          REG_HEIGHT: cfg_height_q <= cfg_data_i[CFG_DIM_W-1:0];
          REG_COLOR:  cfg_color_q  <= cfg_data_i[0];
          default:    cfg_mode_q   <= cfg_mode_q;
        endcase
      end

      if (cmd_i.store) begin
        if (store_en) begin
          load_cnt_q <= load_cnt_q + 1'b1;
        end
        if (frame_done) begin
          readout_q <= 1'b1;
          row_q     <= '0;
          col_q     <= '0;
          chan_q    <= '0;
        end
      end

      if (cmd_i.pos) begin
        if (oob || is_last) begin
          readout_q  <= 1'b0;
          load_cnt_q <= '0;
          row_q      <= '0;
          col_q      <= '0;
          chan_q     <= '0;
        end else begin
          row_q  <= row_nxt;
          col_q  <= col_nxt;
          chan_q <= chan_nxt;
        end
      end

      if (cmd_i.result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      data_q <= in_data_i;
    end
    if (cmd_i.area) begin
      area_q <= CNT_W'(w) * CNT_W'(h);
    end
    if (cmd_i.pos) begin
      sr_q   <= sr_full[COORD_W-1:0];
      sc_q   <= sc_full[COORD_W-1:0];
      k_q    <= chan_q;
      oob_q  <= oob;
      last_q <= is_last;
    end
    if (cmd_i.mul) begin
      prod_q <= PIX_W'(sr_q) * PIX_W'(w);
    end
    if (cmd_i.addr) begin
      addr_q <= pix_addr + ADDR_W'(k_q);
    end
    if (cmd_i.result) begin
      if (oob_q) begin
        out_data_q <= '0;
      end else if (cfg_mode_q == MODE_INVERT) begin
        out_data_q <= ~rd_q;
      end else begin
        out_data_q <= rd_q;
      end
      out_last_q <= oob_q || last_q;
    end
  end

  // Frame store: one write port for loading, one registered read port for readout.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && store_en) begin
      frame_mem[load_cnt_q[ADDR_W-1:0]] <= data_q;
    end
    if (cmd_i.read) begin
      rd_q <= frame_mem[addr_q];
    end
  end

  assign sts_o.readout  = readout_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_last_o     = out_last_q;

endmodule

### rtl/core/frame_flip_rotate_invert.sv
// Top level of the frame flip / rotate / invert block.
// The block first takes a raster frame one byte per load transfer in row-major order
// (one or three bytes per pixel) into a 196608-byte frame store, then returns it one
// byte per fetch transfer, inverted, mirrored, flipped or rotated by 90 degrees as the
// mode register says; the byte with last set ends the readout and loading starts again.
// Items are handled one at a time by a sequencer: a load passes through accept, frame
// size product and store write; a fetch passes through accept, coordinate mapping, row
// times width product, address sum, registered store read and output register load,
// and waits while the output register is not free; an item that is dropped because
// it does not fit the current phase is only accepted. A finished byte waits in the output
// register while the next item is accepted. Registers may be written only when the
// block is idle; the frame store needs no clearing after reset.
module frame_flip_rotate_invert (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ffri_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffri_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ffri_in_if.sink                         in_i,
  ffri_out_if.source                      out_o
);
  import ffri_pkg::*;

  ffri_cmd_t ctrl_cmd;
  ffri_sts_t dp_sts;

  ffri_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  ffri_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data_in),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data_out),
    .out_last_o  (out_o.last)
  );

`ifndef SYNTH
  // A result never overwrites a byte that is still waiting for its transfer.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.result |-> (!out_o.valid || out_o.ready))
    else $error("output register loaded while occupied");

  // Source bytes are written only while the frame is being loaded.
  a_store_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.store |-> !dp_sts.readout)
    else $error("frame store written during readout");

  // Readout positions advance only during readout.
  a_fetch_in_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.pos |-> dp_sts.readout)
    else $error("fetch processed while loading");

  // The mapping step of a fetch is always followed by the product step.
  a_pos_then_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.pos |=> ctrl_cmd.mul)
    else $error("fetch sequence broken after coordinate mapping");
`endif

endmodule

### verif/tb.sv
// Self-checking testbench for the frame flip / rotate / invert block.
`timescale 1ns / 1ps

module tb;
  import ffri_pkg::*;

  localparam int ITEM_BUDGET = 1400;
  localparam int LONG_HOLD   = 120;
  localparam int TAIL_CYCLES = 12;
  localparam int LIMIT_NS    = 3_000_000;

  localparam int FRAME_PLAIN       = 0;
  localparam int FRAME_SHRINK_LOAD = 1;
  localparam int FRAME_CUT_READ    = 2;
  localparam int FRAME_PAUSE       = 3;

  localparam logic [MODE_W-1:0] MODE_UNDEF_TOP = 3'd7;

  typedef struct {
    logic              kind;
    logic [BYTE_W-1:0] data;
  } in_item_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_byte_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ffri_in_if  in_if ();
  ffri_out_if out_if ();

  frame_flip_rotate_invert u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Predictor copy of the registers and the frame engine state.
  logic [MODE_W-1:0]    mode_r;
  logic [CFG_DIM_W-1:0] width_r;
  logic [CFG_DIM_W-1:0] height_r;
  logic                 color_r;
  logic [BYTE_W-1:0]    store_mem [0:STORE_DEPTH-1];
  int unsigned          load_cnt;
  bit                   in_readout;
  int unsigned          row, colm, chan;

  in_item_t  items_to_send[$];
  out_byte_t bytes_due[$];
  in_item_t  next_item;
  out_byte_t want_byte;

  int  fail_count;
  int  useful_items;
  bit  in_taken;
  int  burst_left, gap_left;
  int  hold_asks, hold_done, hold_left;
  int  rx_cycle, rx_style;

  function automatic int unsigned dim_used(logic [CFG_DIM_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_bytes();
    return dim_used(width_r, MAX_WIDTH) * dim_used(height_r, MAX_HEIGHT) *
           (color_r ? PIX_BYTES : 1);
  endfunction

  function automatic bit rotates();
    return (mode_r == MODE_ROT_CW) || (mode_r == MODE_ROT_CCW);
  endfunction

  function automatic void restart_load();
    in_readout = 0;
    load_cnt   = 0;
    row        = 0;
    colm       = 0;
    chan       = 0;
  endfunction

  // Works out what one accepted item does to the engine and queues the byte it yields.
  task automatic step_frame_engine(input logic kind, input logic [BYTE_W-1:0] din);
    int unsigned w, h, ps, total, ow, oh, sr, sc, addr;
    logic [BYTE_W-1:0] b;
    bit fin;
    w     = dim_used(width_r, MAX_WIDTH);
    h     = dim_used(height_r, MAX_HEIGHT);
    ps    = color_r ? PIX_BYTES : 1;
    total = w * h * ps;
    if (!in_readout) begin
      if (kind != KIND_LOAD) return;
      if (load_cnt < total) begin
        store_mem[load_cnt % STORE_DEPTH] = din;
        load_cnt++;
      end
      if (load_cnt >= total) begin
        in_readout = 1;
        row        = 0;
        colm       = 0;
        chan       = 0;
      end
      return;
    end
    if (kind != KIND_FETCH) return;
    ow = rotates() ? h : w;
    oh = rotates() ? w : h;
    // A position left outside the frame by a register change ends the readout.
    if (row >= oh || colm >= ow || chan >= ps) begin
      bytes_due.push_back('{data: '0, last: 1'b1});
      restart_load();
      return;
    end
    case (mode_r)
      MODE_MIRROR: begin
        sr = row;
        sc = w - 1 - colm;
      end
      MODE_FLIP: begin
        sr = h - 1 - row;
        sc = colm;
      end
      MODE_ROT_CW: begin
        sr = h - 1 - colm;
        sc = row;
      end
      MODE_ROT_CCW: begin
        sr = colm;
        sc = w - 1 - row;
      end
      default: begin
        sr = row;
        sc = colm;
      end
    endcase
    addr = (sr * w + sc) * ps + chan;
    b    = store_mem[addr % STORE_DEPTH];
    if (mode_r == MODE_INVERT) b = ~b;
    fin = (row == oh - 1) && (colm == ow - 1) && (chan == ps - 1);
    bytes_due.push_back('{data: b, last: fin});
    if (fin) begin
      restart_load();
    end else begin
      chan++;
      if (chan >= ps) begin
        chan = 0;
        colm++;
        if (colm >= ow) begin
          colm = 0;
          row++;
        end
      end
    end
  endtask

  // Input side: bursts of transfers separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        next_item = items_to_send.pop_front();
        in_if.valid   <= 1'b1;
        in_if.kind    <= next_item.kind;
        in_if.data_in <= next_item.data;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Output side: a stall style re-chosen at random at regular intervals, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 3);
      if (hold_left == 0 && hold_done != hold_asks) begin
        hold_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_style)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= (rx_cycle % 3 == 0);
          default: out_if.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected output byte: data_out %0h last %0b", out_if.data_out, out_if.last);
          fail_count++;
        end else begin
          want_byte = bytes_due.pop_front();
          if (out_if.data_out !== want_byte.data) begin
            $error("data_out mismatch: expected %0h, actual %0h",
                   want_byte.data, out_if.data_out);
            fail_count++;
          end
          if (out_if.last !== want_byte.last) begin
            $error("last mismatch: expected %0b, actual %0b", want_byte.last, out_if.last);
            fail_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) step_frame_engine(in_if.kind, in_if.data_in);
    end
  end

  task automatic send_item(input logic kind, input logic [BYTE_W-1:0] data, input bit useful);
    items_to_send.push_back('{kind: kind, data: data});
    if (useful) useful_items++;
  endtask

  // Returns once everything has been sent and answered and the block has settled.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_if.valid || bytes_due.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MODE:   mode_r   = value[MODE_W-1:0];
      REG_WIDTH:  width_r  = value;
      REG_HEIGHT: height_r = value;
      REG_COLOR:  color_r  = value[0];
    endcase
  endtask

  task automatic load_bytes(input int unsigned n, input bit edge_data, input int noise_pct);
    for (int unsigned j = 0; j < n; j++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(KIND_FETCH, 8'($urandom), 0);
      if (edge_data) send_item(KIND_LOAD, (j % 2) ? 8'hFF : 8'h00, 1);
      else send_item(KIND_LOAD, 8'($urandom), 1);
    end
  endtask

  task automatic fetch_bytes(input int unsigned n, input int noise_pct);
    for (int unsigned j = 0; j < n; j++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(KIND_LOAD, 8'($urandom), 0);
      send_item(KIND_FETCH, 8'($urandom), 1);
    end
  endtask

  task automatic run_frame(input logic [MODE_W-1:0] md, input logic [CFG_DIM_W-1:0] w,
                           input logic [CFG_DIM_W-1:0] h, input logic col, input int shape,
                           input bit edge_data, input bit long_hold, input int noise_pct);
    int unsigned total, ps, wu, hu, span, shown, cut, top;
    logic [CFG_DIM_W-1:0] dim;
    wait_idle();
    write_reg(REG_MODE, CFG_DATA_W'(md));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_COLOR, CFG_DATA_W'(col));
    total = frame_bytes();
    ps    = col ? PIX_BYTES : 1;
    wu    = dim_used(w, MAX_WIDTH);
    hu    = dim_used(h, MAX_HEIGHT);
    if (shape == FRAME_SHRINK_LOAD && hu >= 2) begin
      // Part of the frame goes in, then the height drops so the count already covers it.
      cut = $urandom_range(wu * ps, total - 1);
      load_bytes(cut, edge_data, noise_pct);
      wait_idle();
      write_reg(REG_HEIGHT, CFG_DIM_W'($urandom_range(0, cut / (wu * ps))));
      send_item(KIND_LOAD, 8'($urandom), 1);
      total = frame_bytes();
    end else begin
      load_bytes(total, edge_data, noise_pct);
    end
    if (long_hold) begin
      while (items_to_send.size() != 0) @(posedge clk_i);
      hold_asks++;
    end
    span = (rotates() ? dim_used(height_r, MAX_HEIGHT) : dim_used(width_r, MAX_WIDTH)) * ps;
    if (shape == FRAME_CUT_READ && total >= 2 * span) begin
      // Read a few rows, then shrink the row count to or just past the current row.
      top   = (4 * span < total) ? 4 * span : total - 1;
      shown = $urandom_range(span, top);
      fetch_bytes(shown, noise_pct);
      wait_idle();
      dim = CFG_DIM_W'(shown / span + $urandom_range(0, 1));
      if (rotates()) write_reg(REG_WIDTH, dim);
      else write_reg(REG_HEIGHT, dim);
      fetch_bytes(1, 0);
    end else if (shape == FRAME_PAUSE) begin
      shown = total / 2;
      fetch_bytes(shown, noise_pct);
      wait_idle();
      send_item(KIND_LOAD, 8'($urandom), 0);
      fetch_bytes(total - shown, noise_pct);
    end else begin
      fetch_bytes(total, noise_pct);
    end
    wait_idle();
    while (in_readout) begin
      send_item(KIND_FETCH, 8'($urandom), 1);
      wait_idle();
    end
  endtask

  function automatic logic [CFG_DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_DIM_W'($urandom_range(9, 16));
      default: return CFG_DIM_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    #LIMIT_NS;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int frame_no;
    int shape;
    logic [MODE_W-1:0] md;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_MODE;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.kind    = KIND_LOAD;
    in_if.data_in = '0;
    out_if.ready  = 1'b0;
    mode_r        = MODE_INVERT;
    width_r       = CFG_DIM_W'(RST_WIDTH);
    height_r      = CFG_DIM_W'(RST_HEIGHT);
    color_r       = 1'b0;
    restart_load();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames: a fetch while loading, every mode, both pixel sizes, clamped sizes.
    send_item(KIND_FETCH, 8'hA5, 0);
    run_frame(MODE_INVERT, 1, 1, 1'b1, FRAME_PAUSE, 1, 0, 0);
    run_frame(MODE_MIRROR, 2, 1, 1'b0, FRAME_PLAIN, 0, 0, 0);
    run_frame(MODE_FLIP, 1, 2, 1'b0, FRAME_PLAIN, 0, 0, 0);
    run_frame(MODE_ROT_CW, 2, 2, 1'b0, FRAME_PLAIN, 0, 0, 0);
    run_frame(MODE_ROT_CCW, 2, 2, 1'b0, FRAME_PLAIN, 0, 0, 0);
    run_frame(MODE_UNDEF_TOP, 0, 0, 1'b0, FRAME_PLAIN, 0, 0, 0);

    frame_no = 0;
    while (useful_items < ITEM_BUDGET) begin
      case (frame_no)
        0: run_frame(MODE_ROT_CW, 8, 4, 1'b1, FRAME_PLAIN, 0, 1, 8);
        1: run_frame(MODE_ROT_CCW, 5, 4, 1'b1, FRAME_SHRINK_LOAD, 0, 0, 8);
        2: run_frame(MODE_FLIP, 6, 5, 1'b0, FRAME_CUT_READ, 0, 0, 8);
        3: run_frame(MODE_MIRROR, 4, 3, 1'b1, FRAME_PAUSE, 0, 1, 8);
        4: run_frame(MODE_ROT_CW, 256, 1, 1'b0, FRAME_CUT_READ, 0, 0, 2);
        5: run_frame(MODE_FLIP, 1, 256, 1'b0, FRAME_CUT_READ, 0, 0, 2);
        6: run_frame(MODE_ROT_CCW, 511, 0, 1'b0, FRAME_CUT_READ, 0, 0, 2);
        default: begin
          md = ($urandom_range(0, 7) == 0) ? MODE_W'($urandom_range(5, 7))
                                           : MODE_W'($urandom_range(0, 4));
          case ($urandom_range(0, 7))
            0:       shape = FRAME_SHRINK_LOAD;
            1:       shape = FRAME_CUT_READ;
            2:       shape = FRAME_PAUSE;
            default: shape = FRAME_PLAIN;
          endcase
          run_frame(md, pick_dim(), pick_dim(), 1'($urandom_range(0, 1)), shape, 0,
                    $urandom_range(0, 4) == 0, 8);
        end
      endcase
      frame_no++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
